// File: design/tclp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclp_pkg
// Shared types, character codes and phase encoding for the trace text
// line parser.
// ----------------------------------------------------------------------------
package tclp_pkg;

    localparam int DEFAULT_INDEX_WIDTH = 32;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [5:0] FRAC_MAX = 6'd63;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [7:0] {
        PH_A     = 8'b0000_0001,
        PH_T     = 8'b0000_0010,
        PH_H     = 8'b0000_0100,
        PH_B     = 8'b0000_1000,
        PH_BSKIP = 8'b0001_0000,
        PH_D     = 8'b0010_0000,
        PH_DSKIP = 8'b0100_0000,
        PH_V     = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic               status;
        logic signed [31:0] appl_index;
        logic signed [31:0] task_index;
        logic signed [31:0] thread_index;
        logic signed [63:0] begin_time;
        logic signed [63:0] event_value;
        logic [5:0]         fraction_digits;
        logic               new_location;
        logic signed [63:0] end_time;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_core_res;

    function automatic t_phase next_phase(input t_phase ph);
        t_phase r;
        unique case (ph)
            PH_A:     r = PH_T;
            PH_T:     r = PH_H;
            PH_H:     r = PH_B;
            PH_B:     r = PH_BSKIP;
            PH_BSKIP: r = PH_D;
            PH_D:     r = PH_DSKIP;
            PH_DSKIP: r = PH_V;
            PH_V:     r = PH_V;
            default:  r = PH_A;
        endcase
        return r;
    endfunction

endpackage

// File: design/tclp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclp_core
// Per-byte field phase machine, decimal accumulator, location tracking and
// running end time; produces the line record combinationally on close.
// ----------------------------------------------------------------------------
module tclp_core
    import tclp_pkg::*;
#(
    parameter int INDEX_WIDTH = DEFAULT_INDEX_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    output t_core_res o_res
);

    t_phase                 r_phase, n_phase;
    logic [63:0]            r_acc, n_acc;
    logic                   r_minus, n_minus;
    logic                   r_start, n_start;
    logic                   r_point, n_point;
    logic [5:0]             r_frac, n_frac;
    logic                   r_ignore, n_ignore;
    logic                   r_bad, n_bad;
    logic                   r_has, n_has;
    logic                   r_loc_new, n_loc_new;
    logic [INDEX_WIDTH-1:0] r_held_a, n_held_a;
    logic [INDEX_WIDTH-1:0] r_held_t, n_held_t;
    logic [INDEX_WIDTH-1:0] r_loc [3];
    logic [INDEX_WIDTH-1:0] n_loc [3];
    logic [63:0]            r_begin, n_begin;
    logic [63:0]            r_sum, n_sum;
    logic [63:0]            r_end, n_end;

    logic [7:0]             c;
    logic                   is_nl;
    logic                   is_delim;
    logic [63:0]            fv;
    logic [63:0]            val_out;
    logic                   close;
    logic                   line_bad;
    logic                   loc_new_pre;
    logic [5:0]             frac_pre;
    logic [INDEX_WIDTH-1:0] idx_m [3];
    logic [31:0]            idx_o [3];
    t_out_item              rec;

    assign c     = i_item.text_byte;
    assign is_nl = (c == CH_NL);
    assign fv    = r_minus ? (64'd0 - r_acc) : r_acc;

    always_comb begin
        priority case (1'b1)
            r_phase == PH_H: is_delim = (c == CH_TAB);
            r_phase == PH_V: is_delim = 1'b0;
            default:         is_delim = (c == CH_POINT);
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_minus   = r_minus;
        n_start   = r_start;
        n_point   = r_point;
        n_frac    = r_frac;
        n_ignore  = r_ignore;
        n_bad     = r_bad;
        n_has     = r_has;
        n_loc_new = r_loc_new;
        n_held_a  = r_held_a;
        n_held_t  = r_held_t;
        n_loc     = r_loc;
        n_begin   = r_begin;
        n_sum     = r_sum;
        n_end     = r_end;

        if (!is_nl) begin
            n_has = 1'b1;
            if (r_phase == PH_BSKIP || r_phase == PH_DSKIP) begin
                if (c == CH_TAB) begin
                    n_acc    = '0;
                    n_minus  = 1'b0;
                    n_start  = 1'b1;
                    n_point  = 1'b0;
                    n_frac   = '0;
                    n_ignore = 1'b0;
                    n_phase  = next_phase(r_phase);
                end
            end else if (is_delim) begin
                unique case (r_phase)
                    PH_A: n_held_a = fv[INDEX_WIDTH-1:0];
                    PH_T: n_held_t = fv[INDEX_WIDTH-1:0];
                    PH_H: begin
                        if (!r_bad && (r_held_a != r_loc[0] || r_held_t != r_loc[1] ||
                                       fv[INDEX_WIDTH-1:0] != r_loc[2])) begin
                            n_loc_new = 1'b1;
                            n_loc[0]  = r_held_a;
                            n_loc[1]  = r_held_t;
                            n_loc[2]  = fv[INDEX_WIDTH-1:0];
                        end
                    end
                    PH_B:    n_begin = fv;
                    PH_D:    n_sum   = r_begin + fv;
                    default: ;
                endcase
                n_acc    = '0;
                n_minus  = 1'b0;
                n_start  = 1'b1;
                n_point  = 1'b0;
                n_frac   = '0;
                n_ignore = 1'b0;
                n_phase  = next_phase(r_phase);
            end else if (!r_ignore) begin
                priority if (c == CH_CR || c == CH_NUL) begin
                    n_ignore = 1'b1;
                end else if (c >= CH_ZERO && c <= CH_NINE) begin
                    n_acc   = {r_acc[60:0], 3'b000} + {r_acc[62:0], 1'b0}
                              + {60'd0, c[3:0]};
                    n_start = 1'b0;
                    if (r_point && r_frac < FRAC_MAX) begin
                        n_frac = r_frac + 6'd1;
                    end
                end else if (c == CH_MINUS && r_start) begin
                    n_minus = 1'b1;
                    n_start = 1'b0;
                end else if (c == CH_POINT && r_phase == PH_V && !r_point) begin
                    n_point = 1'b1;
                    n_start = 1'b0;
                end else begin
                    n_bad = 1'b1;
                end
            end
        end

        close       = is_nl ? r_has : i_item.end_of_text;
        line_bad    = n_bad || (n_phase != PH_V);
        val_out     = n_minus ? (64'd0 - n_acc) : n_acc;
        loc_new_pre = n_loc_new;
        frac_pre    = n_frac;

        if (close && !line_bad && ($signed(r_end) < $signed(n_sum))) begin
            n_end = n_sum;
        end

        if ((is_nl && !r_has) || close) begin
            n_phase   = PH_A;
            n_acc     = '0;
            n_minus   = 1'b0;
            n_start   = 1'b1;
            n_point   = 1'b0;
            n_frac    = '0;
            n_ignore  = 1'b0;
            n_bad     = 1'b0;
            n_has     = 1'b0;
            n_loc_new = 1'b0;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            idx_m[k] = n_loc[k] - INDEX_WIDTH'(1);
            idx_o[k] = 32'(64'($signed(idx_m[k])));
        end
    end

    always_comb begin
        rec                 = '0;
        rec.new_location    = loc_new_pre;
        rec.end_time        = n_end;
        if (line_bad) begin
            rec.status = STATUS_BAD;
            if (loc_new_pre) begin
                rec.appl_index   = idx_o[0];
                rec.task_index   = idx_o[1];
                rec.thread_index = idx_o[2];
            end
        end else begin
            rec.status          = STATUS_OK;
            rec.appl_index      = idx_o[0];
            rec.task_index      = idx_o[1];
            rec.thread_index    = idx_o[2];
            rec.begin_time      = r_begin;
            rec.event_value     = val_out;
            rec.fraction_digits = frac_pre;
        end
    end

    assign o_res.valid = i_accept && close;
    assign o_res.item  = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_A;
            r_acc     <= '0;
            r_minus   <= 1'b0;
            r_start   <= 1'b1;
            r_point   <= 1'b0;
            r_frac    <= '0;
            r_ignore  <= 1'b0;
            r_bad     <= 1'b0;
            r_has     <= 1'b0;
            r_loc_new <= 1'b0;
            r_held_a  <= '0;
            r_held_t  <= '0;
            r_loc     <= '{default: '0};
            r_begin   <= '0;
            r_sum     <= '0;
            r_end     <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_acc     <= n_acc;
            r_minus   <= n_minus;
            r_start   <= n_start;
            r_point   <= n_point;
            r_frac    <= n_frac;
            r_ignore  <= n_ignore;
            r_bad     <= n_bad;
            r_has     <= n_has;
            r_loc_new <= n_loc_new;
            r_held_a  <= n_held_a;
            r_held_t  <= n_held_t;
            r_loc     <= n_loc;
            r_begin   <= n_begin;
            r_sum     <= n_sum;
            r_end     <= n_end;
        end
    end

endmodule

// File: design/trace_csv_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_csv_line_parser
// Parses a byte stream of trace text lines into one record per non-empty
// line; the record appears in the cycle after its closing byte.
// Throughput: 1 byte per cycle; a byte is held off only while a record
// waits in the output register and i_out_ready is low.
// Reset: synchronous, active low; clears phase, accumulator, location and
// running end time; no record pending.
// ----------------------------------------------------------------------------
module trace_csv_line_parser
    import tclp_pkg::*;
#(
    parameter int INDEX_WIDTH = DEFAULT_INDEX_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      accept;
    t_core_res core_res;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    tclp_core #(
        .INDEX_WIDTH(INDEX_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_in_item),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_res.valid) begin
            r_out_item <= core_res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: bench/trace_csv_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_csv_line_checker
// Watches both channels of the trace line parser, parses every accepted text
// byte with an independent line parser, queues the expected records and
// compares each accepted record field by field against the oldest one.
// ----------------------------------------------------------------------------
module trace_csv_line_checker
    import tclp_pkg::*;
#(
    parameter int INDEX_WIDTH = DEFAULT_INDEX_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    localparam logic [63:0] IDX_MASK = {64{1'b1}} >> (64 - INDEX_WIDTH);

    t_phase      phase;
    logic [63:0] acc;
    bit          neg;
    bit          fresh;
    bit          pt;
    bit          skip_rest;
    logic [5:0]  frac;
    bit          bad;
    bit          has_bytes;
    bit          loc_new;
    logic [63:0] held [5];
    logic [63:0] loc [3];
    logic [63:0] max_end;

    t_out_item   expected_records [$];
    int          fails = 0;

    assign o_fail_count = fails;

    function automatic t_phase following(input t_phase ph);
        case (ph)
            PH_A:     return PH_T;
            PH_T:     return PH_H;
            PH_H:     return PH_B;
            PH_B:     return PH_BSKIP;
            PH_BSKIP: return PH_D;
            PH_D:     return PH_DSKIP;
            default:  return PH_V;
        endcase
    endfunction

    function automatic int slot_of(input t_phase ph);
        case (ph)
            PH_A:    return 0;
            PH_T:    return 1;
            PH_H:    return 2;
            PH_B:    return 3;
            default: return 4;
        endcase
    endfunction

    function automatic logic [31:0] index_of(input logic [63:0] n);
        logic [63:0] v;
        v = (n - 64'd1) & IDX_MASK;
        if (v[INDEX_WIDTH-1])
            v = v | ~IDX_MASK;
        return v[31:0];
    endfunction

    function automatic logic [63:0] field_value();
        return neg ? (64'd0 - acc) : acc;
    endfunction

    task automatic clear_field();
        acc       = '0;
        neg       = 0;
        fresh     = 1;
        pt        = 0;
        frac      = '0;
        skip_rest = 0;
    endtask

    task automatic end_field();
        bit same;
        held[slot_of(phase)] = field_value();
        if (phase == PH_H && !bad) begin
            same = 1;
            for (int k = 0; k < 3; k++)
                if ((held[k] & IDX_MASK) != (loc[k] & IDX_MASK))
                    same = 0;
            if (!same) begin
                loc_new = 1;
                for (int k = 0; k < 3; k++)
                    loc[k] = held[k];
            end
        end
        clear_field();
        phase = following(phase);
    endtask

    task automatic number_byte(input logic [7:0] c);
        bit delim;
        delim = (phase == PH_H) ? (c == CH_TAB) : (phase != PH_V && c == CH_POINT);
        if (delim) begin
            end_field();
        end else if (!skip_rest) begin
            if (c == CH_CR || c == CH_NUL) begin
                skip_rest = 1;
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
                acc   = acc * 64'd10 + 64'(c - CH_ZERO);
                fresh = 0;
                if (pt && frac < FRAC_MAX)
                    frac = frac + 6'd1;
            end else if (c == CH_MINUS && fresh) begin
                neg   = 1;
                fresh = 0;
            end else if (c == CH_POINT && phase == PH_V && !pt) begin
                pt    = 1;
                fresh = 0;
            end else begin
                bad = 1;
            end
        end
    endtask

    task automatic close_line(output t_out_item r);
        logic [63:0] sum;
        r = '0;
        r.new_location = loc_new;
        if (bad || phase != PH_V) begin
            r.status = STATUS_BAD;
            if (loc_new) begin
                r.appl_index   = index_of(held[0]);
                r.task_index   = index_of(held[1]);
                r.thread_index = index_of(held[2]);
            end
        end else begin
            sum = held[3] + held[4];
            if ($signed(max_end) < $signed(sum))
                max_end = sum;
            r.status          = STATUS_OK;
            r.appl_index      = index_of(held[0]);
            r.task_index      = index_of(held[1]);
            r.thread_index    = index_of(held[2]);
            r.begin_time      = held[3];
            r.event_value     = field_value();
            r.fraction_digits = frac;
        end
        r.end_time = max_end;
        phase      = PH_A;
        clear_field();
        bad        = 0;
        has_bytes  = 0;
        loc_new    = 0;
    endtask

    task automatic parse_byte(input t_in_item it, output bit has_rec, output t_out_item rec);
        has_rec = 0;
        rec     = '0;
        if (it.text_byte == CH_NL) begin
            if (!has_bytes) begin
                phase = PH_A;
                clear_field();
                bad     = 0;
                loc_new = 0;
            end else begin
                close_line(rec);
                has_rec = 1;
            end
        end else begin
            has_bytes = 1;
            if (phase == PH_BSKIP || phase == PH_DSKIP) begin
                if (it.text_byte == CH_TAB) begin
                    clear_field();
                    phase = following(phase);
                end
            end else begin
                number_byte(it.text_byte);
            end
            if (it.end_of_text) begin
                close_line(rec);
                has_rec = 1;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] got);
        if (exp !== got) begin
            $error("%s: expected %0h, actual %0h", name, exp, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        bit        has_rec;
        t_out_item rec;
        t_out_item exp;
        if (!i_rst_n) begin
            phase = PH_A;
            clear_field();
            bad       = 0;
            has_bytes = 0;
            loc_new   = 0;
            for (int k = 0; k < 5; k++)
                held[k] = '0;
            for (int k = 0; k < 3; k++)
                loc[k] = '0;
            max_end = '0;
            expected_records.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_records.size() == 0) begin
                    $error("record with no expected transaction: %0h", i_out_item);
                    fails++;
                end else begin
                    exp = expected_records.pop_front();
                    check_field("status", 64'(exp.status), 64'(i_out_item.status));
                    check_field("appl_index", 64'(exp.appl_index), 64'(i_out_item.appl_index));
                    check_field("task_index", 64'(exp.task_index), 64'(i_out_item.task_index));
                    check_field("thread_index", 64'(exp.thread_index),
                                64'(i_out_item.thread_index));
                    check_field("begin_time", exp.begin_time, i_out_item.begin_time);
                    check_field("event_value", exp.event_value, i_out_item.event_value);
                    check_field("fraction_digits", 64'(exp.fraction_digits),
                                64'(i_out_item.fraction_digits));
                    check_field("new_location", 64'(exp.new_location),
                                64'(i_out_item.new_location));
                    check_field("end_time", exp.end_time, i_out_item.end_time);
                end
            end
            if (i_in_valid && i_in_ready) begin
                parse_byte(i_in_item, has_rec, rec);
                if (has_rec)
                    expected_records.push_back(rec);
            end
        end
        o_pending <= expected_records.size();
    end

endmodule

// File: bench/tb_trace_csv_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trace_csv_line_parser
// Feeds the trace line parser a directed set of lines, then random trace
// lines (mostly well formed, some corrupted, truncated or pure noise) with
// random gaps and stalls on both channels; the checker beside the block
// predicts and compares every record.
// ----------------------------------------------------------------------------
module tb_trace_csv_line_parser;
    import tclp_pkg::*;

    localparam int TARGET_ITEMS = 1950;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    int        fail_count;
    int        pending;

    int         sent = 0;
    bit         tx_burst = 0;
    logic [7:0] line [$];
    int         close_mode;
    string      loc_txt [3];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    trace_csv_line_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    trace_csv_line_checker u_record_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic string digits_text(input int n);
        string s;
        s = "";
        repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    function automatic string number_text();
        string s;
        s = ($urandom_range(0, 3) == 0) ? "-" : "";
        case ($urandom_range(0, 11))
            0:       s = {s, ""};
            7:       s = {s, digits_text($urandom_range(4, 10))};
            8:       s = {s, digits_text($urandom_range(18, 24))};
            9:       s = {s, "99999999999999999999"};
            10:      s = {s, "0"};
            default: s = {s, digits_text($urandom_range(1, 3))};
        endcase
        return s;
    endfunction

    function automatic string value_text();
        string s;
        s = number_text();
        if ($urandom_range(0, 1))
            s = {s, ".", digits_text(($urandom_range(0, 29) == 0) ? $urandom_range(63, 70)
                                                                    : $urandom_range(0, 4))};
        return s;
    endfunction

    function automatic logic [7:0] any_text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
        return b;
    endfunction

    function automatic logic [7:0] skip_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_NL || b == CH_TAB);
        return b;
    endfunction

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line.push_back(s[i]);
    endtask

    task automatic append_skip();
        repeat ($urandom_range(0, 3)) line.push_back(skip_byte());
        line.push_back(CH_TAB);
    endtask

    task automatic build_line();
        int k;
        line.delete();
        if ($urandom_range(0, 2) == 0) begin
            for (k = 0; k < 3; k++)
                loc_txt[k] = number_text();
        end else if ($urandom_range(0, 2) == 0) begin
            loc_txt[$urandom_range(0, 2)] = number_text();
        end
        append_text({loc_txt[0], ".", loc_txt[1], ".", loc_txt[2], "\t"});
        append_text({number_text(), "."});
        append_skip();
        append_text({number_text(), "."});
        append_skip();
        append_text(value_text());
        case ($urandom_range(0, 15))
            0: line.insert($urandom_range(0, line.size()), any_text_byte());
            1: begin
                k = $urandom_range(0, line.size() - 1);
                while (line.size() > k)
                    void'(line.pop_back());
            end
            2: line.insert($urandom_range(0, line.size()),
                           $urandom_range(0, 1) ? CH_CR : CH_NUL);
            3: line.insert($urandom_range(0, line.size()), CH_MINUS);
            4: line.delete();
            5: begin
                line.delete();
                repeat ($urandom_range(1, 8)) line.push_back(any_text_byte());
            end
            6: line.push_back(CH_CR);
            7: line.insert($urandom_range(0, line.size()), CH_POINT);
            default: ;
        endcase
        case ($urandom_range(0, 19))
            0:       close_mode = (line.size() > 0) ? 1 : 0;
            1:       close_mode = 2;
            default: close_mode = 0;
        endcase
    endtask

    task automatic send_item(input logic [7:0] b, input bit last);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid            <= 1'b1;
        in_item.text_byte   <= b;
        in_item.end_of_text <= last;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    initial begin
        int taken;
        int gap;
        bit rx_burst;
        taken    = 0;
        rx_burst = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                rx_burst = !rx_burst;
            gap = (taken == 12) ? 400 : (rx_burst ? 0 : $urandom_range(0, 13));
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    initial begin
        int line_no;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        for (int k = 0; k < 3; k++)
            loc_txt[k] = "1";
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("\n");
        send_text("1.2.3\t-4.a\t5.\t6.7\n");
        send_text("x\n");

        line_no = 0;
        while (sent < TARGET_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                tx_burst = !tx_burst;
            build_line();
            if (line_no == 40) begin
                in_valid <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end
            for (int i = 0; i < line.size(); i++)
                send_item(line[i], close_mode == 1 && i == line.size() - 1);
            if (close_mode != 1)
                send_item(CH_NL, close_mode == 2);
            line_no++;
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
design/tclp_pkg.sv
design/tclp_core.sv
design/trace_csv_line_parser.sv
bench/trace_csv_line_checker.sv
bench/tb_trace_csv_line_parser.sv
